// ===== rtl/bsd_pkg.sv =====
// shared types and constants for the byte stuffed frame deframer
// no dependencies

package bsd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 8;

    // framing characters
    localparam logic [BYTE_W-1:0] CH_START = 8'h46; // 'F'
    localparam logic [BYTE_W-1:0] CH_END   = 8'h45; // 'E'
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'h58; // 'X'
    localparam logic [BYTE_W-1:0] CH_ACK   = 8'h61; // 'a'

    // frame geometry
    localparam logic [POS_W-1:0] ACK_HEADER_LEN  = 8'd7;
    localparam logic [POS_W-1:0] DATA_HEADER_LEN = 8'd16;
    localparam logic [POS_W-1:0] FRAME_MAX_LEN   = 8'd128;

    typedef enum logic [2:0] {
        MODE_HUNT    = 3'd0,
        MODE_FIRST   = 3'd1,
        MODE_HEADER  = 3'd2,
        MODE_BODY    = 3'd3,
        MODE_ESCAPED = 3'd4,
        MODE_ACK_END = 3'd5,
        MODE_CUT     = 3'd6
    } mode_t;

    typedef struct packed {
        logic              frame_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  byte_position;
        logic              end_of_frame;
        logic              truncated;
    } result_t;

endpackage

// ===== rtl/bsd_channels.sv =====
// valid/ready channel interfaces for raw bytes and recovered frame items
// depends on bsd_pkg

interface bsd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [bsd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsd_frame_if;
    logic                       valid;
    logic                       ready;
    logic                       frame_kind;
    logic [bsd_pkg::BYTE_W-1:0] data_byte;
    logic [bsd_pkg::POS_W-1:0]  byte_position;
    logic                       end_of_frame;
    logic                       truncated;

    modport source (output valid, output frame_kind, output data_byte,
                    output byte_position, output end_of_frame, output truncated,
                    input ready);
    modport sink   (input valid, input frame_kind, input data_byte,
                    input byte_position, input end_of_frame, input truncated,
                    output ready);
endinterface

// ===== rtl/bsd_parser.sv =====
// framing state machine: hunts, reads headers, unstuffs bodies
// depends on bsd_pkg

module bsd_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [bsd_pkg::BYTE_W-1:0] rx_byte,
    output logic                       res_valid,
    output bsd_pkg::result_t           res
);

    bsd_pkg::mode_t              mode_reg, mode_next;
    logic [bsd_pkg::POS_W-1:0]   count_reg, count_next;
    logic                        ack_reg, ack_next;

    logic [bsd_pkg::POS_W-1:0]   count_base;
    logic [bsd_pkg::POS_W-1:0]   count_inc;
    logic                        ack_cur;
    bsd_pkg::mode_t              emit_mode;

    // a new frame restarts the count and picks its kind from the first byte
    assign count_base = (mode_reg == bsd_pkg::MODE_FIRST) ? '0 : count_reg;
    assign ack_cur    = (mode_reg == bsd_pkg::MODE_FIRST) ?
                        (rx_byte == bsd_pkg::CH_ACK) : ack_reg;
    assign count_inc  = count_base + bsd_pkg::POS_W'(1);

    // mode after a byte is emitted; length limit wins over header end
    always_comb
    begin
        if (count_inc >= bsd_pkg::FRAME_MAX_LEN)
            emit_mode = bsd_pkg::MODE_CUT;
        else if (ack_cur)
            emit_mode = (count_inc >= bsd_pkg::ACK_HEADER_LEN) ?
                        bsd_pkg::MODE_ACK_END : bsd_pkg::MODE_HEADER;
        else
            emit_mode = (count_inc >= bsd_pkg::DATA_HEADER_LEN) ?
                        bsd_pkg::MODE_BODY : bsd_pkg::MODE_HEADER;
    end

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        ack_next   = ack_reg;
        if (take)
        begin
            unique case (mode_reg)
                bsd_pkg::MODE_FIRST,
                bsd_pkg::MODE_HEADER,
                bsd_pkg::MODE_ESCAPED:
                begin
                    mode_next  = emit_mode;
                    count_next = count_inc;
                    ack_next   = ack_cur;
                end
                bsd_pkg::MODE_BODY:
                begin
                    if (rx_byte == bsd_pkg::CH_END)
                    begin
                        mode_next  = bsd_pkg::MODE_HUNT;
                        count_next = '0;
                        ack_next   = 1'b0;
                    end
                    else if (rx_byte == bsd_pkg::CH_ESC)
                        mode_next = bsd_pkg::MODE_ESCAPED;
                    else
                    begin
                        mode_next  = emit_mode;
                        count_next = count_inc;
                    end
                end
                bsd_pkg::MODE_ACK_END,
                bsd_pkg::MODE_CUT:
                begin
                    mode_next  = bsd_pkg::MODE_HUNT;
                    count_next = '0;
                    ack_next   = 1'b0;
                end
                default:
                begin
                    // hunting, and the unused code behaves the same
                    if (rx_byte == bsd_pkg::CH_START)
                    begin
                        mode_next  = bsd_pkg::MODE_FIRST;
                        count_next = '0;
                        ack_next   = 1'b0;
                    end
                    else
                        mode_next = bsd_pkg::MODE_HUNT;
                end
            endcase
        end
    end

    // result for the item being taken
    always_comb
    begin
        res_valid         = 1'b0;
        res.frame_kind    = ack_cur;
        res.data_byte     = rx_byte;
        res.byte_position = count_base;
        res.end_of_frame  = 1'b0;
        res.truncated     = 1'b0;
        unique case (mode_reg)
            bsd_pkg::MODE_FIRST,
            bsd_pkg::MODE_HEADER,
            bsd_pkg::MODE_ESCAPED:
                res_valid = take;
            bsd_pkg::MODE_BODY:
            begin
                if (rx_byte == bsd_pkg::CH_END)
                begin
                    res_valid        = take;
                    res.data_byte    = '0;
                    res.end_of_frame = 1'b1;
                end
                else
                    res_valid = take && (rx_byte != bsd_pkg::CH_ESC);
            end
            bsd_pkg::MODE_ACK_END,
            bsd_pkg::MODE_CUT:
            begin
                res_valid        = take;
                res.data_byte    = '0;
                res.end_of_frame = 1'b1;
                res.truncated    = (mode_reg == bsd_pkg::MODE_CUT);
            end
            default:
                res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bsd_pkg::MODE_HUNT;
            count_reg <= '0;
            ack_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

// ===== rtl/bsd_out_reg.sv =====
// result register driving the frame channel
// depends on bsd_pkg and bsd_channels

module bsd_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                res_valid,
    input  bsd_pkg::result_t    res,
    output logic                can_load,
    bsd_frame_if.source         frame_chan
);

    logic             valid_reg, valid_next;
    bsd_pkg::result_t data_reg;

    assign can_load = !valid_reg || frame_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
            valid_next = take && res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (can_load && take && res_valid)
            data_reg <= res;
    end

    assign frame_chan.valid         = valid_reg;
    assign frame_chan.frame_kind    = data_reg.frame_kind;
    assign frame_chan.data_byte     = data_reg.data_byte;
    assign frame_chan.byte_position = data_reg.byte_position;
    assign frame_chan.end_of_frame  = data_reg.end_of_frame;
    assign frame_chan.truncated     = data_reg.truncated;

endmodule

// ===== rtl/byte_stuffed_frame_deframer.sv =====
// top level of the byte stuffed frame deframer
// depends on bsd_pkg, bsd_channels, bsd_parser and bsd_out_reg

// Recovers frames from a byte-stuffed channel stream, one raw byte per item on
// rx_chan. While hunting, bytes other than 'F' are dropped; 'F' opens a frame.
// A first header byte of 'a' marks an ack frame whose fixed header passes raw
// and whose following byte is dropped as the end mark; any other first byte
// starts a data frame whose longer header passes raw, after which the body is
// unstuffed ('X' makes the next byte literal, 'E' closes the frame). Each frame
// byte leaves on frame_chan with its position, and every frame ends with one
// end item carrying the frame length in byte_position and data_byte zero; a
// frame that reaches the maximum length is cut, its next byte is dropped and
// its end item has truncated set. Header lengths and the length limit are
// package constants. Rate: one item per clock while frame_chan is ready; each
// byte passes through the state logic into one output register, so results
// appear in the cycle after the byte is accepted. rx_chan.ready is high whenever
// that output register is empty or being read in the same cycle, so a stalled
// frame_chan stalls the input with no loss.

module byte_stuffed_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    bsd_byte_if.sink    rx_chan,
    bsd_frame_if.source frame_chan
);

    logic             take;
    logic             can_load;
    logic             res_valid;
    bsd_pkg::result_t res;

    // accept when the output register has room for a possible result
    assign rx_chan.ready = can_load;
    assign take          = rx_chan.valid && can_load;

    bsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_chan.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    bsd_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res),
        .can_load   (can_load),
        .frame_chan (frame_chan)
    );

endmodule
